[sv/lfb_pkg.sv]
// Shared constants for the landmark frame builder.
// Holds default widths, column codes and the normalizer latency formula.
// No dependencies.
package lfb_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int AXIS_FRAC_DEF  = 14;

  // Column codes on the result channel.
  localparam logic [1:0] COL_X      = 2'd0;
  localparam logic [1:0] COL_Y      = 2'd1;
  localparam logic [1:0] COL_Z      = 2'd2;
  localparam logic [1:0] COL_ORIGIN = 2'd3;

  // Register stages of the normalizer that do not depend on the fraction width:
  // magnitude, leading-one, shift, square, sum, 32 root steps, divide setup, integer quotient bit, sign.
  localparam int NORM_FIXED_STAGES = 40;

  function automatic int norm_latency(input int frac_bits);
    return frac_bits + NORM_FIXED_STAGES;
  endfunction

endpackage

[sv/lfb_delay.sv]
// Enabled delay line that carries a valid bit and a payload word.
// Used by the frame builder core to keep side data aligned with the normalizers.
// No package dependencies.
module lfb_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_vld,
  input  logic [W-1:0] in_data,
  output logic         out_vld,
  output logic [W-1:0] out_data
);

  logic         vld_r [DEPTH];
  logic [W-1:0] dat_r [DEPTH];

  // Valid bits are control state and clear on reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < DEPTH; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // Payload moves along with its valid bit.
  always_ff @(posedge clk) begin
    if (en) begin
      dat_r[0] <= in_data;
      for (int i = 1; i < DEPTH; i++) dat_r[i] <= dat_r[i-1];
    end
  end

  assign out_vld  = vld_r[DEPTH-1];
  assign out_data = dat_r[DEPTH-1];

endmodule

[sv/lfb_norm.sv]
// Pipelined three-component vector normalizer (unit vector in signed Q.F).
// Stages: magnitude, leading one, shift, squares, sum, 32 root steps, divide setup, restoring divide, sign.
// Depends on nothing but its parameters.
module lfb_norm #(
  parameter int VW = 25,
  parameter int F  = 14
) (
  input  logic                clk,
  input  logic                en,
  input  logic [2:0][VW-1:0]  vec,
  output logic [2:0][F+1:0]   unit
);

  localparam int PSW = $clog2(VW);
  localparam int NBW = 31 + F;
  localparam int QW  = F + 1;
  localparam int RSTEPS = 32;

  typedef struct packed {
    logic [2:0][29:0] an;
    logic [2:0]       neg;
    logic             zero;
  } sq_carry_t;

  typedef struct packed {
    logic [63:0] s;
    logic [63:0] res;
    sq_carry_t   c;
  } sq_t;

  typedef struct packed {
    logic [2:0][NBW-1:0] n;
    logic [2:0][32:0]    rem;
    logic [2:0][QW-1:0]  q;
    logic [31:0]         r;
    logic [2:0]          neg;
    logic                zero;
  } div_t;

  logic [2:0][VW-1:0] a0_r;
  logic [2:0]         neg0_r;
  logic [2:0][VW-1:0] a1_r;
  logic [2:0]         neg1_r;
  logic [PSW-1:0]     pos1_r;
  logic               zero1_r;
  sq_carry_t          c2_r;
  logic [2:0][59:0]   sq3_r;
  sq_carry_t          c3_r;
  sq_t                sq_r [RSTEPS+1];
  div_t               div_r [QW+1];

  logic [VW-1:0]      or_v;
  logic [PSW-1:0]     pos_nxt;
  div_t               prep_nxt;

  // Stage 0: split each component into magnitude and sign.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a0_r[i]   <= vec[i][VW-1] ? (~vec[i] + VW'(1)) : vec[i];
        neg0_r[i] <= vec[i][VW-1];
      end
    end
  end

  // Stage 1: the leading one of the OR is the leading one of the largest magnitude.
  always_comb begin
    or_v    = a0_r[0] | a0_r[1] | a0_r[2];
    pos_nxt = '0;
    for (int b = 0; b < VW; b++) begin
      if (or_v[b]) pos_nxt = PSW'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r    <= a0_r;
      neg1_r  <= neg0_r;
      pos1_r  <= pos_nxt;
      zero1_r <= (or_v == '0);
    end
  end

  // Stage 2: common shift puts the leading one at bit 29; right shifts truncate.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c2_r.an[i] <= 30'({a1_r[i], 29'b0} >> pos1_r);
      end
      c2_r.neg  <= neg1_r;
      c2_r.zero <= zero1_r;
    end
  end

  // Stage 3: squares.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq3_r[i] <= 60'(c2_r.an[i]) * 60'(c2_r.an[i]);
      end
      c3_r <= c2_r;
    end
  end

  // Stage 4: sum of squares seeds the root pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0].s   <= 64'(sq3_r[0]) + 64'(sq3_r[1]) + 64'(sq3_r[2]);
      sq_r[0].res <= '0;
      sq_r[0].c   <= c3_r;
    end
  end

  // Integer square root, one result bit per stage.
  for (genvar k = 0; k < RSTEPS; k++) begin : g_root
    localparam logic [63:0] RBIT = 64'(1) << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = sq_r[k].res + RBIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (sq_r[k].s >= trial) begin
          sq_r[k+1].s   <= sq_r[k].s - trial;
          sq_r[k+1].res <= (sq_r[k].res >> 1) + RBIT;
        end else begin
          sq_r[k+1].s   <= sq_r[k].s;
          sq_r[k+1].res <= sq_r[k].res >> 1;
        end
        sq_r[k+1].c <= sq_r[k].c;
      end
    end
  end

  // Divide setup: rounded numerator and the leading partial remainder.
  always_comb begin
    prep_nxt.r    = sq_r[RSTEPS].res[31:0];
    prep_nxt.neg  = sq_r[RSTEPS].c.neg;
    prep_nxt.zero = sq_r[RSTEPS].c.zero;
    for (int i = 0; i < 3; i++) begin
      prep_nxt.n[i]   = NBW'({sq_r[RSTEPS].c.an[i], F'(0)}) + NBW'(prep_nxt.r >> 1);
      prep_nxt.rem[i] = 33'(prep_nxt.n[i] >> QW);
      prep_nxt.q[i]   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) div_r[0] <= prep_nxt;
  end

  // Restoring divide, one quotient bit per stage for all three components.
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int QB = QW - 1 - j;
    div_t div_nxt;
    always_comb begin : p_step
      logic [32:0] part;
      div_nxt = div_r[j];
      for (int i = 0; i < 3; i++) begin
        part = {div_r[j].rem[i][31:0], div_r[j].n[i][QB]};
        if (part >= {1'b0, div_r[j].r}) begin
          div_nxt.rem[i]    = part - {1'b0, div_r[j].r};
          div_nxt.q[i][QB]  = 1'b1;
        end else begin
          div_nxt.rem[i] = part;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) div_r[j+1] <= div_nxt;
    end
  end

  // Final stage: restore signs; a zero vector stays zero.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (div_r[QW].zero) begin
          unit[i] <= '0;
        end else if (div_r[QW].neg[i]) begin
          unit[i] <= ~(F+2)'(div_r[QW].q[i]) + (F+2)'(1);
        end else begin
          unit[i] <= (F+2)'(div_r[QW].q[i]);
        end
      end
    end
  end

endmodule

[sv/landmark_frame_builder_core.sv]
// An accepted item passes two normalizer pipelines of AXIS_FRAC_BITS + 40 stages each,
// the frame stages and the output stage before its first result appears.
// Each item gives four results that share the output port, which takes no new item until
// the last one is accepted; an item that fails the orientation test gives one result only.
// Reset: rst_n synchronous, active low; clears all valid bits and the output stage's busy flag and column.
// Depends on lfb_pkg, lfb_norm and lfb_delay.
module landmark_frame_builder_core #(
  parameter int COORD_BITS     = lfb_pkg::COORD_BITS_DEF,
  parameter int AXIS_FRAC_BITS = lfb_pkg::AXIS_FRAC_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_first_mark_x,
  input  logic signed [COORD_BITS-1:0] in_first_mark_y,
  input  logic signed [COORD_BITS-1:0] in_first_mark_z,
  input  logic signed [COORD_BITS-1:0] in_second_mark_x,
  input  logic signed [COORD_BITS-1:0] in_second_mark_y,
  input  logic signed [COORD_BITS-1:0] in_second_mark_z,
  input  logic signed [COORD_BITS-1:0] in_plane_normal_x,
  input  logic signed [COORD_BITS-1:0] in_plane_normal_y,
  input  logic signed [COORD_BITS-1:0] in_plane_normal_z,
  input  logic signed [COORD_BITS-1:0] in_reference_x,
  input  logic signed [COORD_BITS-1:0] in_reference_y,
  input  logic signed [COORD_BITS-1:0] in_reference_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_column_index,
  output logic signed [COORD_BITS-1:0] out_part_first,
  output logic signed [COORD_BITS-1:0] out_part_second,
  output logic signed [COORD_BITS-1:0] out_part_third,
  output logic                         out_orientation_error,
  output logic                         out_last_column
);

  localparam int C   = COORD_BITS;
  localparam int F   = AXIS_FRAC_BITS;
  localparam int NW  = F + 2;
  localparam int PW  = 2 * NW;
  localparam int KW  = F + 4;
  localparam int SW  = KW + NW;
  localparam int XW  = KW;
  localparam int CW  = XW + NW;
  localparam int ZW  = CW + 1;
  localparam int NL  = lfb_pkg::norm_latency(F);
  localparam int FRAME_STAGES = 7;
  localparam int D2W = 3 * C + 3 * XW + 3 * NW + 1;
  localparam logic [SW-1:0] HALF = SW'(1) << (F - 1);
  localparam logic [C-1:0]  CMIN = {1'b1, {(C-1){1'b0}}};
  localparam logic [C-1:0]  CMAX = {1'b0, {(C-1){1'b1}}};

  // Q.2F back to Q.F, magnitude rounded half away from zero.
  function automatic logic [KW-1:0] shrink(input logic [SW-1:0] v);
    logic [SW-1:0] mag;
    logic [SW-1:0] rnd;
    mag = v[SW-1] ? (~v + SW'(1)) : v;
    rnd = (mag + HALF) >> F;
    return v[SW-1] ? (~KW'(rnd) + KW'(1)) : KW'(rnd);
  endfunction

  logic en;
  logic in_fire;

  logic [2:0][C:0]   d_vec;
  logic [2:0][C-1:0] n_vec;
  logic [2:0][C-1:0] ref_in;
  logic [2:0][NW-1:0] yn;
  logic [2:0][NW-1:0] x0n;
  logic [2:0][NW-1:0] zn;
  logic              vld1;
  logic [3*C-1:0]    ref1;

  logic [2:0][NW-1:0] y1_r, y2_r, y3_r, y4_r, y5_r, y6_r, y7_r;
  logic [2:0][NW-1:0] x01_r, x02_r, x03_r;
  logic [2:0][PW-1:0] p1_r;
  logic [KW-1:0]      dot2_r;
  logic [2:0][SW-1:0] m3_r;
  logic [2:0][XW-1:0] x4_r, x5_r, x6_r, x7_r;
  logic [5:0][CW-1:0] c6_r;
  logic [2:0][ZW-1:0] zf7_r;
  logic               err7_r;

  logic               vld2;
  logic [D2W-1:0]     d2_out;
  logic [2:0][C-1:0]  ref2;
  logic [2:0][XW-1:0] x2o;
  logic [2:0][NW-1:0] y2o;
  logic               err2;

  logic               v8_r;
  logic [2:0][XW-1:0] x8_r;
  logic [2:0][NW-1:0] y8_r;
  logic [2:0][NW-1:0] z8_r;
  logic [2:0][C-1:0]  org8_r;
  logic               err8_r;

  logic               busy_r;
  logic [1:0]         col_r;
  logic [2:0][XW-1:0] xs_r;
  logic [2:0][NW-1:0] ys_r;
  logic [2:0][NW-1:0] zs_r;
  logic [2:0][C-1:0]  orgs_r;
  logic               errs_r;
  logic               out_fire;
  logic               final_col;
  logic               take;

  // Handshake: the whole pipeline advances unless its last stage is held.
  assign out_fire  = busy_r && out_ready;
  assign final_col = errs_r || (col_r == lfb_pkg::COL_ORIGIN);
  assign take      = v8_r && (!busy_r || (out_fire && final_col));
  assign en        = !v8_r || take;
  assign in_ready  = en;
  assign in_fire   = in_valid && in_ready;

  // Landmark difference and plane normal feed the two front normalizers.
  assign d_vec[0] = (C+1)'(in_first_mark_x) - (C+1)'(in_second_mark_x);
  assign d_vec[1] = (C+1)'(in_first_mark_y) - (C+1)'(in_second_mark_y);
  assign d_vec[2] = (C+1)'(in_first_mark_z) - (C+1)'(in_second_mark_z);
  assign n_vec[0] = in_plane_normal_x;
  assign n_vec[1] = in_plane_normal_y;
  assign n_vec[2] = in_plane_normal_z;
  assign ref_in[0] = in_reference_x;
  assign ref_in[1] = in_reference_y;
  assign ref_in[2] = in_reference_z;

  lfb_norm #(.VW(C + 1), .F(F)) u_norm_d (
    .clk (clk), .en (en), .vec (d_vec), .unit (yn)
  );

  lfb_norm #(.VW(C), .F(F)) u_norm_n (
    .clk (clk), .en (en), .vec (n_vec), .unit (x0n)
  );

  // Reference point and item valid ride past the normalizer and frame stages.
  lfb_delay #(.W(3 * C), .DEPTH(NL + FRAME_STAGES)) u_dly_ref (
    .clk (clk), .rst_n (rst_n), .en (en),
    .in_vld (in_fire), .in_data (ref_in),
    .out_vld (vld1), .out_data (ref1)
  );

  // Frame stage 1: y gets its first component negated; dot product terms.
  always_ff @(posedge clk) begin
    if (en) begin
      y1_r[0] <= ~yn[0] + NW'(1);
      y1_r[1] <= yn[1];
      y1_r[2] <= yn[2];
      x01_r   <= x0n;
      p1_r[0] <= PW'($signed(x0n[0])) * (-PW'($signed(yn[0])));
      p1_r[1] <= PW'($signed(x0n[1])) * PW'($signed(yn[1]));
      p1_r[2] <= PW'($signed(x0n[2])) * PW'($signed(yn[2]));
    end
  end

  // Frame stage 2: sum and round the dot product.
  always_ff @(posedge clk) begin
    if (en) begin
      dot2_r <= shrink(SW'($signed(p1_r[0])) + SW'($signed(p1_r[1])) +
                       SW'($signed(p1_r[2])));
      y2_r   <= y1_r;
      x02_r  <= x01_r;
    end
  end

  // Frame stage 3: dot times y.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m3_r[i] <= SW'($signed(dot2_r)) * SW'($signed(y2_r[i]));
      end
      y3_r  <= y2_r;
      x03_r <= x02_r;
    end
  end

  // Frame stage 4: x = x0 + rounded(dot * y).
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        x4_r[i] <= XW'($signed(x03_r[i])) + shrink(m3_r[i]);
      end
      y4_r <= y3_r;
    end
  end

  // Frame stage 5: flip x when its first component is negative.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        x5_r[i] <= x4_r[0][XW-1] ? (~x4_r[i] + XW'(1)) : x4_r[i];
      end
      y5_r <= y4_r;
    end
  end

  // Frame stage 6: cross product terms.
  always_ff @(posedge clk) begin
    if (en) begin
      c6_r[0] <= CW'($signed(x5_r[1])) * CW'($signed(y5_r[2]));
      c6_r[1] <= CW'($signed(x5_r[2])) * CW'($signed(y5_r[1]));
      c6_r[2] <= CW'($signed(x5_r[2])) * CW'($signed(y5_r[0]));
      c6_r[3] <= CW'($signed(x5_r[0])) * CW'($signed(y5_r[2]));
      c6_r[4] <= CW'($signed(x5_r[0])) * CW'($signed(y5_r[1]));
      c6_r[5] <= CW'($signed(x5_r[1])) * CW'($signed(y5_r[0]));
      x6_r    <= x5_r;
      y6_r    <= y5_r;
    end
  end

  // Frame stage 7: exact cross product and the orientation test.
  always_ff @(posedge clk) begin
    if (en) begin
      zf7_r[0] <= ZW'($signed(c6_r[0])) - ZW'($signed(c6_r[1]));
      zf7_r[1] <= ZW'($signed(c6_r[2])) - ZW'($signed(c6_r[3]));
      zf7_r[2] <= ZW'($signed(c6_r[4])) - ZW'($signed(c6_r[5]));
      err7_r   <= ($signed(c6_r[4]) < $signed(c6_r[5]));
      x7_r     <= x6_r;
      y7_r     <= y6_r;
    end
  end

  lfb_norm #(.VW(ZW), .F(F)) u_norm_z (
    .clk (clk), .en (en), .vec (zf7_r), .unit (zn)
  );

  lfb_delay #(.W(D2W), .DEPTH(NL)) u_dly_frame (
    .clk (clk), .rst_n (rst_n), .en (en),
    .in_vld (vld1), .in_data ({ref1, x7_r, y7_r, err7_r}),
    .out_vld (vld2), .out_data (d2_out)
  );

  assign {ref2, x2o, y2o, err2} = d2_out;

  // Last pipeline stage: z with its second component negated, saturated origin.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (en) begin
      v8_r <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x8_r    <= x2o;
      y8_r    <= y2o;
      z8_r[0] <= zn[0];
      z8_r[1] <= ~zn[1] + NW'(1);
      z8_r[2] <= zn[2];
      for (int i = 0; i < 3; i++) begin
        org8_r[i] <= (ref2[i] == CMIN) ? CMAX : (~ref2[i] + C'(1));
      end
      err8_r <= err2;
    end
  end

  // Output stage: holds one frame and sends its columns in order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      col_r  <= lfb_pkg::COL_X;
    end else if (take) begin
      busy_r <= 1'b1;
      col_r  <= lfb_pkg::COL_X;
    end else if (out_fire) begin
      if (final_col) begin
        busy_r <= 1'b0;
      end else begin
        col_r <= col_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      xs_r   <= x8_r;
      ys_r   <= y8_r;
      zs_r   <= z8_r;
      orgs_r <= org8_r;
      errs_r <= err8_r;
    end
  end

  // Column select onto the result ports.
  always_comb begin
    out_part_first  = '0;
    out_part_second = '0;
    out_part_third  = '0;
    if (!errs_r) begin
      unique case (col_r)
        lfb_pkg::COL_X: begin
          out_part_first  = C'($signed(xs_r[0]));
          out_part_second = C'($signed(xs_r[1]));
          out_part_third  = C'($signed(xs_r[2]));
        end
        lfb_pkg::COL_Y: begin
          out_part_first  = C'($signed(ys_r[0]));
          out_part_second = C'($signed(ys_r[1]));
          out_part_third  = C'($signed(ys_r[2]));
        end
        lfb_pkg::COL_Z: begin
          out_part_first  = C'($signed(zs_r[0]));
          out_part_second = C'($signed(zs_r[1]));
          out_part_third  = C'($signed(zs_r[2]));
        end
        lfb_pkg::COL_ORIGIN: begin
          out_part_first  = orgs_r[0];
          out_part_second = orgs_r[1];
          out_part_third  = orgs_r[2];
        end
      endcase
    end
  end

  assign out_valid             = busy_r;
  assign out_column_index      = errs_r ? lfb_pkg::COL_X : col_r;
  assign out_orientation_error = errs_r;
  assign out_last_column       = final_col;

endmodule

[sv/lfb_checker.sv]
// Port-level checks on the result channel of the frame builder core.
// Depends on lfb_pkg; bound to landmark_frame_builder_core at the end of this file.
module lfb_checker #(
  parameter int COORD_BITS = lfb_pkg::COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [1:0]            out_column_index,
  input logic [COORD_BITS-1:0] out_part_first,
  input logic [COORD_BITS-1:0] out_part_second,
  input logic [COORD_BITS-1:0] out_part_third,
  input logic                  out_orientation_error,
  input logic                  out_last_column
);

  // A stalled result item holds its column and error flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_column_index) &&
      $stable(out_orientation_error) && $stable(out_part_first))
    else $error("result item changed while stalled");

  // An error item is a lone, final item in column zero with zero parts.
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_orientation_error |-> out_last_column &&
      out_column_index == lfb_pkg::COL_X && out_part_first == '0 &&
      out_part_second == '0 && out_part_third == '0)
    else $error("malformed orientation error item");

  // Only the origin column or an error item closes a frame.
  a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_last_column ==
      (out_orientation_error || out_column_index == lfb_pkg::COL_ORIGIN))
    else $error("last flag on wrong column");

  // Columns of one frame follow each other without a gap.
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_column |=> out_valid &&
      out_column_index == $past(out_column_index) + 2'd1)
    else $error("column sequence broken");

endmodule

bind landmark_frame_builder_core lfb_checker #(.COORD_BITS(COORD_BITS)) u_lfb_checker (.*);

[tb/landmark_frame_builder_core_tb.sv]
// Self-checking testbench for landmark_frame_builder_core.
// Predicts the frame columns from each accepted landmark item and checks every result.
// Depends on lfb_pkg and the landmark_frame_builder_core RTL.
`timescale 1ns / 1ps

module landmark_frame_builder_core_tb;

  localparam int CW = lfb_pkg::COORD_BITS_DEF;
  localparam int FB = lfb_pkg::AXIS_FRAC_DEF;
  localparam int DRAIN_CYCLES = 2 * FB + 89 + 100;
  localparam longint CYCLE_LIMIT = 600000;

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t landmark_item_t [12];
  typedef longint vec3_t [3];

  typedef struct {
    logic [1:0]    column;
    logic [CW-1:0] first;
    logic [CW-1:0] second;
    logic [CW-1:0] third;
    logic          orient_err;
    logic          last;
  } frame_column_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  coord_t in_f [12];
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_column_index;
  coord_t out_part_first, out_part_second, out_part_third;
  logic out_orientation_error, out_last_column;

  frame_column_t pending_columns [$];
  int fail_count = 0;
  longint cycle_count = 0;

  initial begin
    for (int i = 0; i < 12; i++) in_f[i] = '0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  landmark_frame_builder_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_first_mark_x(in_f[0]), .in_first_mark_y(in_f[1]), .in_first_mark_z(in_f[2]),
    .in_second_mark_x(in_f[3]), .in_second_mark_y(in_f[4]), .in_second_mark_z(in_f[5]),
    .in_plane_normal_x(in_f[6]), .in_plane_normal_y(in_f[7]), .in_plane_normal_z(in_f[8]),
    .in_reference_x(in_f[9]), .in_reference_y(in_f[10]), .in_reference_z(in_f[11]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_column_index(out_column_index),
    .out_part_first(out_part_first), .out_part_second(out_part_second),
    .out_part_third(out_part_third),
    .out_orientation_error(out_orientation_error), .out_last_column(out_last_column)
  );

  // Integer square root, floor.
  function automatic logic [63:0] int_sqrt(input logic [63:0] s);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] abs64(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Scale to unit length in Q.FB; a zero vector stays zero.
  function automatic void unit_vector(input vec3_t v, output vec3_t o);
    logic [63:0] a [3];
    logic [63:0] peak, sumsq, root, q;
    peak = 0;
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = abs64(v[i]);
      if (a[i] > peak) peak = a[i];
    end
    if (peak == 0) begin
      o = '{0, 0, 0};
      return;
    end
    while (peak >= (64'd1 << 30)) begin
      peak = peak >> 1;
      for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
    end
    while (peak < (64'd1 << 29)) begin
      peak = peak << 1;
      for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
    end
    for (int i = 0; i < 3; i++) sumsq = sumsq + a[i] * a[i];
    root = int_sqrt(sumsq);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << FB) + (root >> 1)) / root;
      o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
  endfunction

  // Q.2F product back to Q.F, magnitude rounded half away from zero.
  function automatic longint round_product(input longint v);
    logic [63:0] m;
    m = (abs64(v) + (64'd1 << (FB - 1))) >> FB;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  // Work out the frame columns for one item and queue them.
  function automatic void predict_frame(input landmark_item_t f);
    vec3_t d, nrm, y, x0, x, zf, z, org;
    longint dot, dot_r, v;
    longint hi, lo;
    frame_column_t c;
    hi = (longint'(1) << (CW - 1)) - 1;
    lo = -hi - 1;
    for (int i = 0; i < 3; i++) begin
      d[i] = longint'(f[i]) - longint'(f[3 + i]);
      nrm[i] = longint'(f[6 + i]);
    end
    unit_vector(d, y);
    y[0] = -y[0];
    unit_vector(nrm, x0);
    dot = x0[0] * y[0] + x0[1] * y[1] + x0[2] * y[2];
    dot_r = round_product(dot);
    for (int i = 0; i < 3; i++) x[i] = x0[i] + round_product(dot_r * y[i]);
    if (x[0] < 0) for (int i = 0; i < 3; i++) x[i] = -x[i];
    zf[0] = x[1] * y[2] - x[2] * y[1];
    zf[1] = x[2] * y[0] - x[0] * y[2];
    zf[2] = x[0] * y[1] - x[1] * y[0];
    if (zf[2] < 0) begin
      c = '{lfb_pkg::COL_X, '0, '0, '0, 1'b1, 1'b1};
      pending_columns.push_back(c);
      return;
    end
    unit_vector(zf, z);
    z[1] = -z[1];
    for (int i = 0; i < 3; i++) begin
      v = -longint'(f[9 + i]);
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      org[i] = v;
    end
    pending_columns.push_back('{lfb_pkg::COL_X, x[0][CW-1:0], x[1][CW-1:0], x[2][CW-1:0],
                                1'b0, 1'b0});
    pending_columns.push_back('{lfb_pkg::COL_Y, y[0][CW-1:0], y[1][CW-1:0], y[2][CW-1:0],
                                1'b0, 1'b0});
    pending_columns.push_back('{lfb_pkg::COL_Z, z[0][CW-1:0], z[1][CW-1:0], z[2][CW-1:0],
                                1'b0, 1'b0});
    pending_columns.push_back('{lfb_pkg::COL_ORIGIN, org[0][CW-1:0], org[1][CW-1:0],
                                org[2][CW-1:0], 1'b0, 1'b1});
  endfunction

  // Cycle counter with a hard limit on run time.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver stalls: the pattern steps through four modes as the cycle count advances.
  always @(posedge clk) begin
    case ((cycle_count >> 9) % 4)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(1, 0) == 1);
      2: out_ready <= ($urandom_range(7, 0) == 0);
      default: out_ready <= (cycle_count[2:0] != 3'd5);
    endcase
  end

  task automatic compare_field(input string name, input logic [CW-1:0] exp_v,
                               input logic [CW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Check each accepted result against the oldest expected column.
  always @(posedge clk) begin
    frame_column_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_columns.size() == 0) begin
        $error("result with no expected column");
        fail_count++;
      end else begin
        e = pending_columns.pop_front();
        compare_field("column_index", CW'(e.column), CW'(out_column_index));
        compare_field("part_first", e.first, out_part_first);
        compare_field("part_second", e.second, out_part_second);
        compare_field("part_third", e.third, out_part_third);
        compare_field("orientation_error", CW'(e.orient_err), CW'(out_orientation_error));
        compare_field("last_column", CW'(e.last), CW'(out_last_column));
      end
    end
  end

  // Drive one item and hold it until it is accepted; called at a rising edge.
  task automatic send_item(input landmark_item_t f);
    for (int i = 0; i < 12; i++) in_f[i] <= f[i];
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_frame(f);
  endtask

  task automatic pause_sender(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic landmark_item_t item_of(input int a, b, c, d, e, g, h, k, m,
                                             n, p, q);
    landmark_item_t f;
    f = '{coord_t'(a), coord_t'(b), coord_t'(c), coord_t'(d), coord_t'(e), coord_t'(g),
          coord_t'(h), coord_t'(k), coord_t'(m), coord_t'(n), coord_t'(p), coord_t'(q)};
    return f;
  endfunction

  // Extreme field values, zero vectors and origin saturation.
  task automatic test_extremes();
    int mx, mn;
    mx = (1 << (CW - 1)) - 1;
    mn = -(1 << (CW - 1));
    send_item(item_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(item_of(mx, mx, mx, mn, mn, mn, mx, mx, mx, mn, mn, mn));
    send_item(item_of(mn, mx, mn, mx, mn, mx, mn, mn, mn, mx, mx, mx));
    send_item(item_of(mx, mn, mx, mn, mx, mn, mx, mn, mx, mn, mx, mn));
    pause_sender(3);
    send_item(item_of(256, 512, 0, 256, 512, 0, 0, 0, 256, mn, 0, mx));
    send_item(item_of(0, 256, 0, 0, 0, 0, 0, 0, 0, 1, -1, mn));
    send_item(item_of(1, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    send_item(item_of(-1, -1, -1, 0, 0, 0, -1, -1, -1, -1, -1, -1));
  endtask

  // Frames that fail the orientation test and ones that just pass it.
  task automatic test_orientation();
    send_item(item_of(0, -256, 0, 0, 0, 0, 256, 0, 0, 10, 20, 30));
    send_item(item_of(0, 256, 0, 0, 0, 0, 256, 0, 0, 10, 20, 30));
    send_item(item_of(0, -256, 0, 0, 0, 0, -256, 0, 0, -5, 0, 5));
    pause_sender(1);
    send_item(item_of(100, 200, 300, -50, 25, 0, 0, 0, 512, 0, 0, 0));
    send_item(item_of(100, -200, 300, -50, 25, 0, 0, 0, -512, 0, 0, 0));
    send_item(item_of(0, 0, 256, 0, 0, 0, 0, 0, 256, 7, 7, 7));
  endtask

  function automatic coord_t random_coord(input int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(8192, 0)) - 4096);
      default: return coord_t'($signed($urandom_range(512, 0)) - 256);
    endcase
  endfunction

  // Random frames in bursts, mostly modest coordinates, some full range or degenerate.
  task automatic test_random(input int count);
    landmark_item_t f;
    int burst, sel, mode;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99, 0);
      mode = (sel < 30) ? 0 : (sel < 65) ? 1 : 2;
      for (int i = 0; i < 12; i++) f[i] = random_coord(mode);
      if (sel >= 90 && sel < 95) for (int i = 0; i < 3; i++) f[3 + i] = f[i];
      if (sel >= 95) for (int i = 0; i < 3; i++) f[6 + i] = '0;
      if (burst == 0) begin
        burst = $urandom_range(20, 1);
        if ($urandom_range(3, 0) != 0) pause_sender($urandom_range(12, 1));
      end
      burst--;
      send_item(f);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_orientation();
    test_random(450);
    in_valid <= 1'b0;
    while (pending_columns.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/lfb_pkg.sv
sv/lfb_delay.sv
sv/lfb_norm.sv
sv/landmark_frame_builder_core.sv
sv/lfb_checker.sv
tb/landmark_frame_builder_core_tb.sv
